/* src/wfcg_pkg.sv */
// ----------------------------------------------------------------------------
// wfcg_pkg: shared types and constants of the windowed FIR coefficient generator
// Fixed-point constants, register indexes, mode codes, CORDIC table and the
// payload records that travel down the pipeline.
// ----------------------------------------------------------------------------
package wfcg_pkg;

	// limits and defaults
	localparam int MAX_TAPS          = 256;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ROT_W             = 33;

	// register indexes
	localparam logic [2:0] REG_WINDOW_KIND = 3'd0;
	localparam logic [2:0] REG_FILTER_KIND = 3'd1;
	localparam logic [2:0] REG_TAP_COUNT   = 3'd2;
	localparam logic [2:0] REG_CUTOFF_LOW  = 3'd3;
	localparam logic [2:0] REG_CUTOFF_HIGH = 3'd4;

	// window codes
	localparam logic [1:0] WIN_RECT = 2'd0;
	localparam logic [1:0] WIN_HANN = 2'd1;
	localparam logic [1:0] WIN_HAMM = 2'd2;

	// filter codes
	localparam logic [1:0] FILT_LOW  = 2'd0;
	localparam logic [1:0] FILT_HIGH = 2'd1;
	localparam logic [1:0] FILT_BAND = 2'd2;
	localparam logic [1:0] FILT_STOP = 2'd3;

	// fixed-point constants (Q30, but H_ONE and the coefficient limits are Q16)
	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic [28:0]             INV_PI_Q30  = 29'd341782638;
	localparam logic signed [33:0]      ONE_Q30     = 34'sd1073741824;
	localparam logic signed [33:0]      HAM_A_Q30   = 34'sd579820585;
	localparam logic signed [29:0]      HAM_B_Q30   = 30'sd493921239;
	localparam logic signed [18:0]      H_ONE       = 19'sd65536;
	localparam logic signed [52:0]      ROUND_HALF  = 53'sd536870912;
	localparam logic signed [52:0]      COEF_MAX    = 53'sd131071;
	localparam logic signed [52:0]      COEF_MIN    = -53'sd131072;

	// arctangent of 2^-i as a binary angle, 2^32 per turn
	localparam logic [31:0] ATAN_TAB [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// one CORDIC rotator lane
	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
		logic                    flip;
	} rot_t;

	// side data while the window phase is divided
	typedef struct packed {
		logic               oor;
		logic               kneg;
		logic [6:0]         kabs;
		logic               kzero;
		logic [15:0]        p1;
		logic [15:0]        p2;
		logic signed [18:0] hctr;
		logic               wone;
		logic               whamm;
	} fr_side_t;

	// side data through the rotators
	typedef struct packed {
		logic               oor;
		logic               kneg;
		logic [6:0]         kabs;
		logic               kzero;
		logic signed [18:0] hctr;
		logic               wone;
		logic               whamm;
	} rot_side_t;

	// side data while the impulse response is divided by k
	typedef struct packed {
		logic               oor;
		logic               neg;
		logic               kzero;
		logic signed [18:0] hctr;
		logic signed [33:0] w;
	} hd_side_t;

	// fold a binary angle into the right half plane, start vector at 1/gain
	function automatic rot_t cordic_prep(input logic [31:0] ang);
		logic signed [ROT_W-1:0] za;
		rot_t                    r;
		za     = $signed({ang[31], ang});
		r.x    = CORDIC_GAIN;
		r.y    = '0;
		r.z    = za;
		r.flip = 1'b0;
		if (za > 33'sd1073741824) begin
			r.z    = za - 33'sd2147483648;
			r.flip = 1'b1;
		end else if (za < -33'sd1073741824) begin
			r.z    = za + 33'sd2147483648;
			r.flip = 1'b1;
		end
		return r;
	endfunction

endpackage

/* src/wfcg_div_cell.sv */
// ----------------------------------------------------------------------------
// wfcg_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in; side data rides along.
// ----------------------------------------------------------------------------
module wfcg_div_cell #(
	parameter int D_W    = 8,
	parameter int N_W    = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [D_W-1:0]    in_rem,
	input  logic [N_W-1:0]    in_num,
	input  logic [D_W-1:0]    in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [D_W-1:0]    out_rem,
	output logic [N_W-1:0]    out_num,
	output logic [D_W-1:0]    out_den,
	output logic [SIDE_W-1:0] out_side
);

	logic [D_W:0]   cat;
	logic [D_W+1:0] diff;
	logic           fits;
	logic [D_W-1:0] rem_nxt;
	logic [N_W-1:0] num_nxt;

	logic              valid_s1;
	logic [D_W-1:0]    rem_s1;
	logic [N_W-1:0]    num_s1;
	logic [D_W-1:0]    den_s1;
	logic [SIDE_W-1:0] side_s1;

	// trial subtract
	always_comb begin
		cat     = {in_rem, in_num[N_W-1]};
		diff    = {1'b0, cat} - {2'b00, in_den};
		fits    = !diff[D_W+1];
		rem_nxt = fits ? diff[D_W-1:0] : cat[D_W-1:0];
		num_nxt = {in_num[N_W-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_nxt;
			num_s1  <= num_nxt;
			den_s1  <= in_den;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_rem   = rem_s1;
	assign out_num   = num_s1;
	assign out_den   = den_s1;
	assign out_side  = side_s1;

endmodule

/* src/wfcg_cordic_cell.sv */
// ----------------------------------------------------------------------------
// wfcg_cordic_cell: one rotation-mode CORDIC micro-rotation
// Rotates every lane by the arctangent of 2^-STAGE toward a zero residual
// angle; side data rides along.
// ----------------------------------------------------------------------------
module wfcg_cordic_cell
	import wfcg_pkg::*;
#(
	parameter int LANES  = 3,
	parameter int STAGE  = 0,
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  rot_t [LANES-1:0]       in_rot,
	input  logic [SIDE_W-1:0]      in_side,
	output logic                   out_valid,
	output rot_t [LANES-1:0]       out_rot,
	output logic [SIDE_W-1:0]      out_side
);

	localparam logic signed [ROT_W-1:0] ATAN = $signed({1'b0, ATAN_TAB[STAGE]});

	rot_t [LANES-1:0]  nxt;
	logic              valid_s1;
	rot_t [LANES-1:0]  rot_s1;
	logic [SIDE_W-1:0] side_s1;

	// micro-rotation per lane
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			nxt[l].flip = in_rot[l].flip;
			if (!in_rot[l].z[ROT_W-1]) begin
				nxt[l].x = $signed(in_rot[l].x) - ($signed(in_rot[l].y) >>> STAGE);
				nxt[l].y = $signed(in_rot[l].y) + ($signed(in_rot[l].x) >>> STAGE);
				nxt[l].z = $signed(in_rot[l].z) - ATAN;
			end else begin
				nxt[l].x = $signed(in_rot[l].x) + ($signed(in_rot[l].y) >>> STAGE);
				nxt[l].y = $signed(in_rot[l].y) - ($signed(in_rot[l].x) >>> STAGE);
				nxt[l].z = $signed(in_rot[l].z) + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1  <= nxt;
			side_s1 <= in_side;
		end
	end

	assign out_valid = valid_s1;
	assign out_rot   = rot_s1;
	assign out_side  = side_s1;

endmodule

/* src/windowed_fir_coefficient_generator_top.sv */
// ----------------------------------------------------------------------------
// windowed_fir_coefficient_generator_top: windowed FIR coefficient generator
// Path: front register, window divide cells, rotation cells, s2 and s3, response
// divide cells, s4 and output register. Throughput: one word per cycle unless
// the output word is held, set by the divide and rotation cells, one step each.
// Reset: asynchronous, clears pipeline valids and loads the registers with
// rectangular, lowpass, one tap and zero cutoffs.
// ----------------------------------------------------------------------------
module windowed_fir_coefficient_generator_top
	import wfcg_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         tap_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] coefficient,
	output logic               index_out_of_range
);

	localparam int FR_W  = $bits(fr_side_t);
	localparam int ROT_SW = $bits(rot_side_t);
	localparam int HD_W  = $bits(hd_side_t);
	localparam int DIV_N = 17;

	// configuration registers
	logic [1:0]  wk_q;
	logic [1:0]  fk_q;
	logic [7:0]  tc_q;
	logic [15:0] cl_q;
	logic [15:0] ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_q <= WIN_RECT;
			fk_q <= FILT_LOW;
			tc_q <= 8'd1;
			cl_q <= '0;
			ch_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_KIND: wk_q <= cfg_wdata[1:0];
				REG_FILTER_KIND: fk_q <= cfg_wdata[1:0];
				REG_TAP_COUNT:   tc_q <= cfg_wdata[7:0];
				REG_CUTOFF_LOW:  cl_q <= cfg_wdata;
				REG_CUTOFF_HIGH: ch_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the output word is held
	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// front end: centre offset, sine phases, centre tap, window dividend
	logic [7:0]         nt;
	logic [7:0]         den;
	logic [6:0]         tao;
	logic signed [8:0]  k;
	logic [8:0]         kneg_abs;
	logic [15:0]        kx;
	logic [15:0]        c1c;
	logic [15:0]        c2c;
	logic signed [18:0] c1x;
	logic signed [18:0] c2x;
	logic [23:0]        dvd;
	fr_side_t           fr_nxt;

	always_comb begin
		nt       = tc_q | 8'd1;
		den      = nt - 8'd1;
		tao      = den[7:1];
		k        = $signed({1'b0, tap_index}) - $signed({2'b00, tao});
		kneg_abs = 9'(-k);
		kx       = {{7{k[8]}}, k};
		c1c      = (cl_q > 16'd32768) ? 16'd32768 : cl_q;
		c2c      = (ch_q > 16'd32768) ? 16'd32768 : ch_q;
		c1x      = $signed({2'b00, c1c, 1'b0});
		c2x      = $signed({2'b00, c2c, 1'b0});
		dvd      = {tap_index, 16'h0000} + 24'(den[7:1]);

		fr_nxt.oor   = (tap_index >= nt) || (32'(tap_index) >= 32'(MAX_TAPS));
		fr_nxt.kneg  = k[8];
		fr_nxt.kabs  = k[8] ? kneg_abs[6:0] : k[6:0];
		fr_nxt.kzero = (k == 9'sd0);
		fr_nxt.p1    = 16'(c1c * kx);
		fr_nxt.p2    = 16'(c2c * kx);
		unique case (fk_q)
			FILT_LOW:  fr_nxt.hctr = c1x;
			FILT_HIGH: fr_nxt.hctr = H_ONE - c1x;
			FILT_BAND: fr_nxt.hctr = c2x - c1x;
			FILT_STOP: fr_nxt.hctr = H_ONE + c1x - c2x;
			default:   fr_nxt.hctr = c1x;
		endcase
		fr_nxt.wone  = (nt == 8'd1) || !(wk_q == WIN_HANN || wk_q == WIN_HAMM);
		fr_nxt.whamm = (wk_q == WIN_HAMM);
	end

	logic        v_s1;
	fr_side_t    fr_s1;
	logic [7:0]  wrem_s1;
	logic [16:0] wnum_s1;
	logic [7:0]  wden_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s1   <= fr_nxt;
			wrem_s1 <= {1'b0, dvd[23:17]};
			wnum_s1 <= dvd[16:0];
			wden_s1 <= den;
		end
	end

	// window phase divider chain: n * 2^16 / (N - 1), rounded
	logic              d1_valid [0:DIV_N];
	logic [7:0]        d1_rem   [0:DIV_N];
	logic [16:0]       d1_num   [0:DIV_N];
	logic [7:0]        d1_den   [0:DIV_N];
	logic [FR_W-1:0]   d1_side  [0:DIV_N];

	assign d1_valid[0] = v_s1;
	assign d1_rem[0]   = wrem_s1;
	assign d1_num[0]   = wnum_s1;
	assign d1_den[0]   = wden_s1;
	assign d1_side[0]  = fr_s1;

	for (genvar i = 0; i < DIV_N; i++) begin : g_wdiv
		wfcg_div_cell #(
			.D_W    (8),
			.N_W    (17),
			.SIDE_W (FR_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (d1_valid[i]),
			.in_rem    (d1_rem[i]),
			.in_num    (d1_num[i]),
			.in_den    (d1_den[i]),
			.in_side   (d1_side[i]),
			.out_valid (d1_valid[i+1]),
			.out_rem   (d1_rem[i+1]),
			.out_num   (d1_num[i+1]),
			.out_den   (d1_den[i+1]),
			.out_side  (d1_side[i+1])
		);
	end

	// rotator chain: two cutoff sines and the window cosine
	fr_side_t  fr_last;
	rot_side_t rs_first;

	logic              cr_valid [0:CORDIC_STAGES];
	rot_t [2:0]        cr_rot   [0:CORDIC_STAGES];
	logic [ROT_SW-1:0] cr_side  [0:CORDIC_STAGES];

	always_comb begin
		fr_last        = fr_side_t'(d1_side[DIV_N]);
		rs_first.oor   = fr_last.oor;
		rs_first.kneg  = fr_last.kneg;
		rs_first.kabs  = fr_last.kabs;
		rs_first.kzero = fr_last.kzero;
		rs_first.hctr  = fr_last.hctr;
		rs_first.wone  = fr_last.wone;
		rs_first.whamm = fr_last.whamm;
	end

	assign cr_valid[0]  = d1_valid[DIV_N];
	assign cr_rot[0][0] = cordic_prep({fr_last.p1, 16'h0000});
	assign cr_rot[0][1] = cordic_prep({fr_last.p2, 16'h0000});
	assign cr_rot[0][2] = cordic_prep({d1_num[DIV_N][15:0], 16'h0000});
	assign cr_side[0]   = rs_first;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		wfcg_cordic_cell #(
			.LANES  (3),
			.STAGE  (i),
			.SIDE_W (ROT_SW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (cr_valid[i]),
			.in_rot    (cr_rot[i]),
			.in_side   (cr_side[i]),
			.out_valid (cr_valid[i+1]),
			.out_rot   (cr_rot[i+1]),
			.out_side  (cr_side[i+1])
		);
	end

	// sine combination, its magnitude, and the window terms
	rot_side_t               rs_last;
	logic signed [ROT_W-1:0] sin_a;
	logic signed [ROT_W-1:0] sin_b;
	logic signed [ROT_W-1:0] cos_w;
	logic signed [33:0]      num;
	logic [32:0]             absnum;
	logic signed [33:0]      hann;
	logic signed [62:0]      hamprod;

	always_comb begin
		rs_last = rot_side_t'(cr_side[CORDIC_STAGES]);
		sin_a   = cr_rot[CORDIC_STAGES][0].flip ? -cr_rot[CORDIC_STAGES][0].y
			: cr_rot[CORDIC_STAGES][0].y;
		sin_b   = cr_rot[CORDIC_STAGES][1].flip ? -cr_rot[CORDIC_STAGES][1].y
			: cr_rot[CORDIC_STAGES][1].y;
		cos_w   = cr_rot[CORDIC_STAGES][2].flip ? -cr_rot[CORDIC_STAGES][2].x
			: cr_rot[CORDIC_STAGES][2].x;
		unique case (fk_q)
			FILT_LOW:  num = 34'(sin_a);
			FILT_HIGH: num = -34'(sin_a);
			FILT_BAND: num = 34'(sin_b) - 34'(sin_a);
			FILT_STOP: num = 34'(sin_a) - 34'(sin_b);
			default:   num = 34'(sin_a);
		endcase
		absnum  = num[33] ? 33'(-num) : 33'(num);
		hann    = (ONE_Q30 - 34'(cos_w)) >>> 1;
		hamprod = 63'(HAM_B_Q30) * 63'(cos_w);
	end

	logic               v_s2;
	rot_side_t          rs_s2;
	logic [32:0]        absnum_s2;
	logic               neg_s2;
	logic signed [33:0] hann_s2;
	logic signed [62:0] hamprod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= cr_valid[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rs_s2      <= rs_last;
			absnum_s2  <= absnum;
			neg_s2     <= num[33] ^ rs_last.kneg;
			hann_s2    <= hann;
			hamprod_s2 <= hamprod;
		end
	end

	// scale by 1/pi and pick the window value
	logic [61:0]        at;
	logic signed [33:0] wsel;
	hd_side_t           hd_nxt;

	always_comb begin
		at = 62'(absnum_s2) * 62'(INV_PI_Q30);
		priority if (rs_s2.wone) begin
			wsel = ONE_Q30;
		end else if (rs_s2.whamm) begin
			wsel = HAM_A_Q30 - 34'(hamprod_s2 >>> 30);
		end else begin
			wsel = hann_s2;
		end
		hd_nxt.oor   = rs_s2.oor;
		hd_nxt.neg   = neg_s2;
		hd_nxt.kzero = rs_s2.kzero;
		hd_nxt.hctr  = rs_s2.hctr;
		hd_nxt.w     = wsel;
	end

	logic        v_s3;
	logic [61:0] at_s3;
	logic [6:0]  kabs_s3;
	hd_side_t    hd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			at_s3   <= at;
			kabs_s3 <= rs_s2.kabs;
			hd_s3   <= hd_nxt;
		end
	end

	// impulse response divider chain: round half away of at / (|k| * 2^44)
	logic [62:0] a_sum;
	assign a_sum = 63'(at_s3) + (63'(kabs_s3) << 43);

	logic            d2_valid [0:DIV_N];
	logic [6:0]      d2_rem   [0:DIV_N];
	logic [16:0]     d2_num   [0:DIV_N];
	logic [6:0]      d2_den   [0:DIV_N];
	logic [HD_W-1:0] d2_side  [0:DIV_N];

	assign d2_valid[0] = v_s3;
	assign d2_rem[0]   = '0;
	assign d2_num[0]   = a_sum[60:44];
	assign d2_den[0]   = kabs_s3;
	assign d2_side[0]  = hd_s3;

	for (genvar i = 0; i < DIV_N; i++) begin : g_hdiv
		wfcg_div_cell #(
			.D_W    (7),
			.N_W    (17),
			.SIDE_W (HD_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (d2_valid[i]),
			.in_rem    (d2_rem[i]),
			.in_num    (d2_num[i]),
			.in_den    (d2_den[i]),
			.in_side   (d2_side[i]),
			.out_valid (d2_valid[i+1]),
			.out_rem   (d2_rem[i+1]),
			.out_num   (d2_num[i+1]),
			.out_den   (d2_den[i+1]),
			.out_side  (d2_side[i+1])
		);
	end

	// ideal response times window
	hd_side_t           hd_last;
	logic signed [18:0] hq;
	logic signed [18:0] h;

	always_comb begin
		hd_last = hd_side_t'(d2_side[DIV_N]);
		hq      = $signed({2'b00, d2_num[DIV_N]});
		if (hd_last.kzero) begin
			h = hd_last.hctr;
		end else begin
			h = hd_last.neg ? -hq : hq;
		end
	end

	logic               v_s4;
	logic               oor_s4;
	logic signed [52:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= d2_valid[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s4  <= hd_last.oor;
			prod_s4 <= 53'(h) * 53'(hd_last.w);
		end
	end

	// round half up to Q16, saturate, output word register
	logic signed [52:0] rnd;
	logic signed [17:0] sat;

	always_comb begin
		rnd = (prod_s4 + ROUND_HALF) >>> 30;
		priority if (rnd > COEF_MAX) begin
			sat = 18'sd131071;
		end else if (rnd < COEF_MIN) begin
			sat = -18'sd131072;
		end else begin
			sat = rnd[17:0];
		end
	end

	logic signed [17:0] coef_q;
	logic               oor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_q <= oor_s4 ? '0 : sat;
			oor_q  <= oor_s4;
		end
	end

	assign out_valid          = out_valid_q;
	assign coefficient        = coef_q;
	assign index_out_of_range = oor_q;

	// an out of range word always carries a zero coefficient
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_out_of_range |-> coefficient == '0)
		else $error("out of range word with nonzero coefficient");

	// a held output freezes the front stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(wnum_s1))
		else $error("front stage moved during stall");

	// window divider leaves a remainder below the divisor
	a_wdiv_rem: assert property (@(posedge clk) disable iff (!arst_n)
		d1_valid[DIV_N] && !fr_last.oor && d1_den[DIV_N] != 8'd0
		|-> d1_rem[DIV_N] < d1_den[DIV_N])
		else $error("window divider remainder out of range");

	// response divider leaves a remainder below |k|
	a_hdiv_rem: assert property (@(posedge clk) disable iff (!arst_n)
		d2_valid[DIV_N] && !hd_last.oor && !hd_last.kzero
		|-> d2_rem[DIV_N] < d2_den[DIV_N])
		else $error("response divider remainder out of range");

endmodule

/* tb/sv/wfcg_checker.sv */
// ----------------------------------------------------------------------------
// wfcg_checker: coefficient predictor and scoreboard
// Tracks register writes, computes the windowed coefficient for every
// accepted tap index word and compares each coefficient word in order.
// ----------------------------------------------------------------------------
module wfcg_checker
	import wfcg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         tap_index,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [17:0] coefficient,
	input  logic               index_out_of_range,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct {
		logic signed [17:0] coef;
		logic               oor;
	} coef_word_t;

	// shadow copy of the registers
	logic [1:0]  win_kind;
	logic [1:0]  filt_kind;
	logic [7:0]  ntaps;
	logic [15:0] cut_lo;
	logic [15:0] cut_hi;

	coef_word_t expected_coefs[$];

	assign outstanding = expected_coefs.size();

	// rotation-mode sine and cosine in Q30
	function automatic void rotate(input logic [31:0] ang, output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit     flip;
		z    = longint'(ang);
		x    = 652032874;
		y    = 0;
		flip = 0;
		if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
		if (z > 64'sd1073741824) begin
			z    = z - 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z    = z + 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_TAB[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_TAB[i]);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint sine_of(input logic [15:0] cut, input int k);
		logic [31:0] p;
		longint      s, c;
		p = 32'(cut) * 32'(k);
		rotate({p[15:0], 16'd0}, s, c);
		return s;
	endfunction

	// windowed coefficient for one tap index
	function automatic coef_word_t predict_coef(input logic [7:0] n);
		coef_word_t      r;
		int unsigned     nt, tao, den, ph;
		int              k;
		longint          h, w, v, num, t, s, c, c1, c2;
		longint unsigned at, d, q;
		nt = ntaps | 8'd1;
		c1 = cut_lo > 16'd32768 ? 32768 : cut_lo;
		c2 = cut_hi > 16'd32768 ? 32768 : cut_hi;
		r.coef = '0;
		r.oor  = 1'b1;
		if (n >= nt) return r;
		r.oor = 1'b0;
		tao = (nt - 1) / 2;
		k   = int'(n) - int'(tao);
		if (k == 0) begin
			case (filt_kind)
				FILT_LOW:  h = 2 * c1;
				FILT_HIGH: h = 65536 - 2 * c1;
				FILT_BAND: h = 2 * (c2 - c1);
				default:   h = 65536 + 2 * (c1 - c2);
			endcase
		end else begin
			case (filt_kind)
				FILT_LOW:  num = sine_of(c1[15:0], k);
				FILT_HIGH: num = -sine_of(c1[15:0], k);
				FILT_BAND: num = sine_of(c2[15:0], k) - sine_of(c1[15:0], k);
				default:   num = sine_of(c1[15:0], k) - sine_of(c2[15:0], k);
			endcase
			t  = num * 341782638;
			at = t < 0 ? -t : t;
			d  = longint'(k < 0 ? -k : k) << 44;
			q  = (at + d / 2) / d;
			h  = ((t < 0) != (k < 0)) ? -longint'(q) : longint'(q);
		end
		if (nt == 1 || !(win_kind == WIN_HANN || win_kind == WIN_HAMM)) begin
			w = 1073741824;
		end else begin
			den = nt - 1;
			ph  = ((int'(n) << 16) + den / 2) / den;
			rotate({ph[15:0], 16'd0}, s, c);
			if (win_kind == WIN_HANN) w = (64'sd1073741824 - c) >>> 1;
			else w = 64'sd579820585 - ((64'sd493921239 * c) >>> 30);
		end
		v = (h * w + 64'sd536870912) >>> 30;
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		r.coef = v[17:0];
		return r;
	endfunction

	// register shadow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_kind  <= WIN_RECT;
			filt_kind <= FILT_LOW;
			ntaps     <= 8'd1;
			cut_lo    <= '0;
			cut_hi    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_KIND: win_kind  <= cfg_wdata[1:0];
				REG_FILTER_KIND: filt_kind <= cfg_wdata[1:0];
				REG_TAP_COUNT:   ntaps     <= cfg_wdata[7:0];
				REG_CUTOFF_LOW:  cut_lo    <= cfg_wdata;
				REG_CUTOFF_HIGH: cut_hi    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// predict on accepted index words, compare accepted coefficient words
	initial mismatches = 0;
	always @(posedge clk) begin
		coef_word_t e;
		if (arst_n && in_valid && in_ready) expected_coefs.push_back(predict_coef(tap_index));
		if (arst_n && out_valid && out_ready) begin
			if (expected_coefs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected coefficient word: coef %0d oor %0b",
						coefficient, index_out_of_range);
			end else begin
				e = expected_coefs.pop_front();
				if (e.coef !== coefficient || e.oor !== index_out_of_range) begin
					mismatches++;
					if (mismatches <= 10)
						$display("coefficient mismatch: expected %0d/%0b, got %0d/%0b",
							e.coef, e.oor, coefficient, index_out_of_range);
				end
			end
		end
	end

endmodule

/* tb/sv/tb_windowed_fir_coefficient_generator_top.sv */
// ----------------------------------------------------------------------------
// tb_windowed_fir_coefficient_generator_top: coefficient generator testbench
// Directed corner cases then random phases of register settings and tap
// indexes under varying idle and stall patterns, checked by wfcg_checker.
// ----------------------------------------------------------------------------
module tb_windowed_fir_coefficient_generator_top;
	import wfcg_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int         DRAIN_CYCLES = 70;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         tap_index;
	logic               out_valid;
	logic               out_ready;
	logic signed [17:0] coefficient;
	logic               index_out_of_range;
	int                 mismatches;
	int                 outstanding;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 cur_taps;

	windowed_fir_coefficient_generator_top u_top (.*);

	wfcg_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// run limit
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	// one register write, enable dropped at a falling edge before returning
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
		if (idx == REG_TAP_COUNT) cur_taps = val[7:0];
	endtask

	task automatic set_filter(input logic [1:0] win, input logic [1:0] filt,
		input logic [7:0] n, input logic [15:0] c1, input logic [15:0] c2);
		write_reg(REG_WINDOW_KIND, 16'(win));
		write_reg(REG_FILTER_KIND, 16'(filt));
		write_reg(REG_TAP_COUNT, 16'(n));
		write_reg(REG_CUTOFF_LOW, c1);
		write_reg(REG_CUTOFF_HIGH, c2);
	endtask

	// one index word, called at a falling edge, returns at a falling edge
	task automatic send_index(input logic [7:0] n);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		tap_index <= n;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// let the pipeline empty before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int          wsel;
		logic [15:0] c1, c2;
		logic [7:0]  nt;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_WINDOW_KIND;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		tap_index      = '0;
		out_ready      = 1'b1;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cur_taps       = 1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single tap at reset values, index past the end
		send_index(8'd0);
		send_index(8'd1);
		send_index(8'd255);
		drain();
		// full length lowpass hanning, ends and centre
		set_filter(WIN_HANN, FILT_LOW, 8'd255, 16'd16384, 16'd0);
		send_index(8'd0);
		send_index(8'd127);
		send_index(8'd254);
		send_index(8'd255);
		drain();
		// highpass hamming, even length raised to odd, cutoff above pi
		set_filter(WIN_HAMM, FILT_HIGH, 8'd20, 16'd65535, 16'd0);
		send_index(8'd10);
		send_index(8'd3);
		send_index(8'd20);
		send_index(8'd21);
		drain();
		// bandpass with reversed cutoffs, spare window code
		set_filter(2'd3, FILT_BAND, 8'd31, 16'd30000, 16'd2000);
		send_index(8'd15);
		send_index(8'd14);
		send_index(8'd0);
		drain();
		// bandstop centre saturates, zero tap count, ignored register index
		set_filter(WIN_RECT, FILT_STOP, 8'd0, 16'd32768, 16'd0);
		write_reg(REG_SPARE, 16'hFFFF);
		send_index(8'd0);
		send_index(8'd1);
		drain();
		set_filter(WIN_HAMM, FILT_STOP, 8'd9, 16'd40000, 16'd32769);
		send_index(8'd4);
		send_index(8'd2);
		send_index(8'd8);
		drain();

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 5)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				3: begin send_idle_pct = 20; recv_stall_pct = 20; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			wsel = $urandom_range(0, 3);
			nt = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd1 : 8'($urandom_range(0, 255));
			c1 = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
			c2 = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
			if (ph == 2) begin c1 = 16'd0; c2 = 16'd32768; end
			set_filter(2'(wsel), 2'($urandom_range(0, 3)), nt, c1, c2);
			for (int i = 0; i < 150; i++) begin
				if ($urandom_range(0, 9) == 0) send_index(8'($urandom));
				else send_index(8'($urandom_range(0, cur_taps | 1)));
			end
			drain();
		end

		if (mismatches == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/wfcg_pkg.sv
src/wfcg_div_cell.sv
src/wfcg_cordic_cell.sv
src/windowed_fir_coefficient_generator_top.sv
tb/sv/wfcg_checker.sv
tb/sv/tb_windowed_fir_coefficient_generator_top.sv
